@@ src/pva_pkg.sv @@
// Package for the polyphonic voice allocator.
// Holds field widths, function and register codes, controller state, command
// and status structs, and the frequency rounding helper. No dependencies.
`default_nettype none

package pva_pkg;

	localparam int FUNC_W     = 2;
	localparam int NOTE_W     = 8;
	localparam int FREQ_W     = 19;
	localparam int VOICE_W    = 3;
	localparam int SHIFT_W    = 12;
	localparam int RATIO_W    = 18;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 18;
	localparam int PROD_W     = FREQ_W + RATIO_W;
	localparam int FSUM_W     = FREQ_W + 3;

	localparam logic [FREQ_W-1:0]  FREQ_MAX  = {FREQ_W{1'b1}};
	localparam logic [RATIO_W-1:0] RATIO_ONE = 18'd65536;

	localparam logic [FUNC_W-1:0] FUNC_START    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STOP     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP_ALL = 2'd2;

	localparam logic ACT_TRIGGER = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_HZ     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RATIO_SECOND = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RATIO_THIRD  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_EMIT_TRIG,
		ST_EMIT_REL,
		ST_REL_ALL
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic start_commit;
		logic stop_commit;
		logic mul_a;
		logic mul_b;
		logic mul_c;
		logic emit_trig;
		logic emit_rel;
		logic emit_relall;
	} pva_cmd_t;

	typedef struct packed {
		logic in_start;
		logic in_stop;
		logic in_all;
		logic item_start;
		logic scan_done;
		logic found;
		logic out_free;
		logic relall_last;
	} pva_sts_t;

	// Round half up from Q.16 and clamp to the frequency range.
	function automatic logic [FREQ_W-1:0] round_sat(input logic [PROD_W-1:0] p);
		logic [PROD_W:0]    sum;
		logic [PROD_W-16:0] q;
		sum = {1'b0, p} + (PROD_W+1)'(32768);
		q   = sum[PROD_W:16];
		if (q > (PROD_W-15)'(FREQ_MAX))
			return FREQ_MAX;
		return q[FREQ_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/pva_if.sv @@
// Channel interfaces of the voice allocator: note requests in, voice words
// out, and the register write channel. Depends on pva_pkg.
`default_nettype none

interface pva_in_if;
	logic                        valid;
	logic                        ready;
	logic [pva_pkg::FUNC_W-1:0]  func;
	logic [pva_pkg::NOTE_W-1:0]  note_id;
	logic [pva_pkg::FREQ_W-1:0]  frequency;
	modport source (output valid, func, note_id, frequency, input ready);
	modport sink   (input valid, func, note_id, frequency, output ready);
endinterface

interface pva_out_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [pva_pkg::VOICE_W-1:0] voice;
	logic [pva_pkg::FREQ_W-1:0]  freq_main;
	logic [pva_pkg::FREQ_W-1:0]  freq_second;
	logic [pva_pkg::FREQ_W-1:0]  freq_third;
	logic                        last;
	modport source (output valid, action, voice, freq_main, freq_second, freq_third, last,
		input ready);
	modport sink   (input valid, action, voice, freq_main, freq_second, freq_third, last,
		output ready);
endinterface

interface pva_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pva_pkg::CFG_ADDR_W-1:0] addr;
	logic [pva_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ src/poly_voice_allocator.sv @@
// Top level of the polyphonic voice allocator.
// Depends on pva_pkg, pva_if, pva_ctrl and pva_dp.
//
//   channel    dir  carries                                           handshake
//   note_in    in   func, note_id, frequency                          valid/ready
//   voice_out  out  action, voice, freq_main/second/third, last       valid/ready
//   cfg        in   addr (0 shift_hz, 1 ratio_second, 2 ratio_third), valid/ready
//                   data
//
// A start scans the note table, commits, runs the multiply steps and emits; a stop
// scans, commits and emits; a stop-all emits one release per voice. The note table
// lookup reads its memory one entry per cycle; the detune multiplier is shared by the
// second and third frequency. Reset clears the note table and refills the free-voice
// FIFO at once, with no clearing pass. A stalled voice_out holds the one-word output
// register and the controller waits before writing the next word into it.
`default_nettype none

module poly_voice_allocator #(
	parameter int VOICES = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pva_in_if.sink     note_in,
	pva_out_if.source  voice_out,
	pva_cfg_if.sink    cfg
);
	import pva_pkg::*;

	pva_cmd_t cmd;
	pva_sts_t st;

	pva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (note_in.valid),
		.in_ready (note_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pva_dp #(
		.VOICES (VOICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (note_in.func),
		.note_id   (note_in.note_id),
		.frequency (note_in.frequency),
		.cmd       (cmd),
		.st        (st),
		.cfg       (cfg),
		.vout      (voice_out)
	);

endmodule

`default_nettype wire

@@ src/pva_ctrl.sv @@
// Controller state machine of the voice allocator.
// Sequences scan, commit, multiply and emit steps of the datapath. Depends on pva_pkg.
`default_nettype none

module pva_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pva_pkg::pva_sts_t st,
	output pva_pkg::pva_cmd_t      cmd
);
	import pva_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (st.in_start || st.in_stop)
						state_d = ST_SCAN;
					else if (st.in_all)
						state_d = ST_REL_ALL;
					else
						state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (st.found && st.item_start)
					state_d = ST_IDLE;
				else if (st.item_start) begin
					cmd.start_commit = 1'b1;
					state_d          = ST_MUL_A;
				end else if (st.found) begin
					cmd.stop_commit = 1'b1;
					state_d         = ST_EMIT_REL;
				end else
					state_d = ST_IDLE;
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_c = 1'b1;
				state_d   = ST_EMIT_TRIG;
			end
			ST_EMIT_TRIG: begin
				if (st.out_free) begin
					cmd.emit_trig = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT_REL: begin
				if (st.out_free) begin
					cmd.emit_rel = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_REL_ALL: begin
				if (st.out_free) begin
					cmd.emit_relall = 1'b1;
					if (st.relall_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_trig || cmd.emit_rel || cmd.emit_relall) |-> st.out_free)
		else $error("voice word emitted into a full output register");

	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> st.scan_done)
		else $error("decision taken before the note table scan finished");

endmodule

`default_nettype wire

@@ src/pva_dp.sv @@
// Datapath of the voice allocator: config registers, note table and free-voice
// FIFO memories, frequency multiply, output register. Depends on pva_pkg, pva_if.
`default_nettype none

module pva_dp #(
	parameter int VOICES = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [pva_pkg::FUNC_W-1:0] func,
	input  wire logic [pva_pkg::NOTE_W-1:0] note_id,
	input  wire logic [pva_pkg::FREQ_W-1:0] frequency,
	input  wire pva_pkg::pva_cmd_t        cmd,
	output pva_pkg::pva_sts_t             st,
	pva_cfg_if.sink                       cfg,
	pva_out_if.source                     vout
);
	import pva_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam int SW = CW + 1;

	// configuration
	logic signed [SHIFT_W-1:0] shift_q;
	logic [RATIO_W-1:0]        ratio2_q, ratio3_q;

	// latched item
	logic [FUNC_W-1:0] func_q;
	logic [NOTE_W-1:0] note_q;
	logic [FREQ_W-1:0] freq_q;

	// note table and free-voice FIFO
	logic [NOTE_W-1:0] held_mem [VOICES];
	logic [VOICES-1:0] held_vld_q;
	logic [VW-1:0]     fifo_mem [VOICES];
	logic [VOICES-1:0] fifo_vld_q;
	logic [VW-1:0]     head_q;
	logic [CW-1:0]     count_q;

	// scan
	logic [CW-1:0]     idx_q;
	logic              rd_go_s1, rd_vld_s1;
	logic [NOTE_W-1:0] rd_note_s1;
	logic [VW-1:0]     rd_idx_s1;
	logic              found_q;
	logic [VW-1:0]     match_q;

	// FIFO head read
	logic [VW-1:0] fifo_rd_s1, head_idx_s1;
	logic          fifo_hv_s1;
	logic [VW-1:0] head_entry, pop_voice;
	logic [SW-1:0] tail_sum, tail_wrap;
	logic [VW-1:0] tail;

	// frequency path
	logic signed [FSUM_W-1:0] fsum;
	logic [FREQ_W-1:0]        fm_d, fm_q, f2_q, f3_q;
	logic [RATIO_W-1:0]       ratio_sel;
	logic [PROD_W-1:0]        prod_q;
	logic [VW-1:0]            voice_q;

	// output register
	logic               ov_q;
	logic               o_action_q, o_last_q;
	logic [VOICE_W-1:0] o_voice_q;
	logic [FREQ_W-1:0]  o_f1_q, o_f2_q, o_f3_q;

	logic scan_rd, relall_last;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			ratio2_q <= RATIO_ONE;
			ratio3_q <= RATIO_ONE;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_SHIFT_HZ:     shift_q  <= cfg.data[SHIFT_W-1:0];
				REG_RATIO_SECOND: ratio2_q <= cfg.data[RATIO_W-1:0];
				REG_RATIO_THIRD:  ratio3_q <= cfg.data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			note_q <= note_id;
			freq_q <= frequency;
		end
	end

	assign scan_rd     = cmd.scan && (idx_q < CW'(VOICES));
	assign relall_last = (idx_q == CW'(VOICES - 1));

	// Scan and stop-all share the index; a new item rewinds it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_go_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			rd_go_s1 <= scan_rd;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (scan_rd || cmd.emit_relall)
				idx_q <= idx_q + CW'(1);
			if (rd_go_s1 && rd_vld_s1 && (rd_note_s1 == note_q) && !found_q)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_note_s1 <= held_mem[idx_q[VW-1:0]];
		rd_vld_s1  <= held_vld_q[idx_q[VW-1:0]];
		rd_idx_s1  <= idx_q[VW-1:0];
		if (rd_go_s1 && rd_vld_s1 && (rd_note_s1 == note_q) && !found_q)
			match_q <= rd_idx_s1;
	end

	// FIFO head entry; an entry never pushed holds its own index
	always_ff @(posedge clk) begin
		fifo_rd_s1  <= fifo_mem[head_q];
		fifo_hv_s1  <= fifo_vld_q[head_q];
		head_idx_s1 <= head_q;
	end

	assign head_entry = fifo_hv_s1 ? fifo_rd_s1 : head_idx_s1;
	assign pop_voice  = (count_q != '0) ? head_entry : '0;
	assign tail_sum   = SW'(head_q) + SW'(count_q);
	assign tail_wrap  = (tail_sum >= SW'(VOICES)) ? tail_sum - SW'(VOICES) : tail_sum;
	assign tail       = tail_wrap[VW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.start_commit)
			held_mem[pop_voice] <= note_q;
		if (cmd.stop_commit && (count_q < CW'(VOICES)))
			fifo_mem[tail] <= match_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= '0;
			fifo_vld_q <= '0;
			head_q     <= '0;
			count_q    <= CW'(VOICES);
		end else if (cmd.emit_relall && relall_last) begin
			held_vld_q <= '0;
			fifo_vld_q <= '0;
			head_q     <= '0;
			count_q    <= CW'(VOICES);
		end else if (cmd.start_commit) begin
			held_vld_q[pop_voice] <= 1'b1;
			if (count_q != '0) begin
				head_q  <= (head_q == VW'(VOICES - 1)) ? '0 : head_q + VW'(1);
				count_q <= count_q - CW'(1);
			end
		end else if (cmd.stop_commit) begin
			held_vld_q[match_q] <= 1'b0;
			if (count_q < CW'(VOICES)) begin
				fifo_vld_q[tail] <= 1'b1;
				count_q          <= count_q + CW'(1);
			end
		end
	end

	// base plus sixteen times the shift, clamped
	always_comb begin
		fsum = $signed({3'b000, freq_q})
			+ $signed({{(FSUM_W-SHIFT_W-4){shift_q[SHIFT_W-1]}}, shift_q, 4'b0000});
		if (fsum[FSUM_W-1])
			fm_d = '0;
		else if (|fsum[FSUM_W-2:FREQ_W])
			fm_d = FREQ_MAX;
		else
			fm_d = fsum[FREQ_W-1:0];
	end

	assign ratio_sel = cmd.mul_b ? ratio3_q : ratio2_q;

	always_ff @(posedge clk) begin
		if (cmd.start_commit) begin
			fm_q    <= fm_d;
			voice_q <= pop_voice;
		end
		if (cmd.stop_commit)
			voice_q <= match_q;
		if (cmd.mul_a || cmd.mul_b)
			prod_q <= PROD_W'(fm_q) * PROD_W'(ratio_sel);
		if (cmd.mul_b)
			f2_q <= round_sat(prod_q);
		if (cmd.mul_c)
			f3_q <= round_sat(prod_q);
	end

	// one-word output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.emit_trig || cmd.emit_rel || cmd.emit_relall)
			ov_q <= 1'b1;
		else if (vout.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_trig) begin
			o_action_q <= ACT_TRIGGER;
			o_voice_q  <= VOICE_W'(voice_q);
			o_f1_q     <= fm_q;
			o_f2_q     <= f2_q;
			o_f3_q     <= f3_q;
			o_last_q   <= 1'b1;
		end else if (cmd.emit_rel || cmd.emit_relall) begin
			o_action_q <= ACT_RELEASE;
			o_voice_q  <= cmd.emit_rel ? VOICE_W'(voice_q) : VOICE_W'(idx_q);
			o_f1_q     <= '0;
			o_f2_q     <= '0;
			o_f3_q     <= '0;
			o_last_q   <= cmd.emit_rel | relall_last;
		end
	end

	assign vout.valid       = ov_q;
	assign vout.action      = o_action_q;
	assign vout.voice       = o_voice_q;
	assign vout.freq_main   = o_f1_q;
	assign vout.freq_second = o_f2_q;
	assign vout.freq_third  = o_f3_q;
	assign vout.last        = o_last_q;

	always_comb begin
		st.in_start    = (func == FUNC_START) && (note_id != '0);
		st.in_stop     = (func == FUNC_STOP) && (note_id != '0);
		st.in_all      = (func == FUNC_STOP_ALL);
		st.item_start  = (func_q == FUNC_START);
		st.scan_done   = (idx_q == CW'(VOICES)) && !rd_go_s1;
		st.found       = found_q;
		st.out_free    = !ov_q || vout.ready;
		st.relall_last = relall_last;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(VOICES))
		else $error("free-voice count above the number of voices");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_relall && relall_last) |=> (count_q == CW'(VOICES)) && (head_q == '0))
		else $error("free-voice FIFO not refilled after stop-all");

endmodule

`default_nettype wire

@@ test/poly_voice_allocator_test.sv @@
// Testbench for poly_voice_allocator: drives note requests and register writes,
// predicts every voice word in a scoreboard class and checks it on arrival.
// Depends on pva_pkg, pva_if and the allocator RTL.
`default_nettype none

module poly_voice_allocator_test;
	import pva_pkg::*;

	localparam int VOICES       = 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE       = VOICES + 12;
	localparam int RANDOM_PHASE = 48;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic               action;
		logic [VOICE_W-1:0] voice;
		logic [FREQ_W-1:0]  freq_main;
		logic [FREQ_W-1:0]  freq_second;
		logic [FREQ_W-1:0]  freq_third;
		logic               last;
	} voice_word_t;

	class voice_scoreboard;
		logic [NOTE_W-1:0]         held [VOICES];
		logic [VOICE_W-1:0]        free_voices [VOICES];
		int                        head;
		int                        free_count;
		logic signed [SHIFT_W-1:0] shift_hz;
		logic [RATIO_W-1:0]        ratio_second;
		logic [RATIO_W-1:0]        ratio_third;
		voice_word_t               pending [$];
		int                        mismatches;

		function new();
			shift_hz     = '0;
			ratio_second = RATIO_ONE;
			ratio_third  = RATIO_ONE;
			mismatches   = 0;
			foreach (held[i])
				held[i] = '0;
			refill();
		endfunction

		function void refill();
			foreach (free_voices[i])
				free_voices[i] = VOICE_W'(i);
			head       = 0;
			free_count = VOICES;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_SHIFT_HZ:     shift_hz     = data[SHIFT_W-1:0];
				REG_RATIO_SECOND: ratio_second = data[RATIO_W-1:0];
				REG_RATIO_THIRD:  ratio_third  = data[RATIO_W-1:0];
				default: ;
			endcase
		endfunction

		// Q2.16 detune, round half up, clamp high.
		function logic [FREQ_W-1:0] detune(logic [FREQ_W-1:0] f, logic [RATIO_W-1:0] r);
			longint p;
			p = (longint'(f) * longint'(r) + 32768) >>> 16;
			if (p > longint'(FREQ_MAX))
				return FREQ_MAX;
			return p[FREQ_W-1:0];
		endfunction

		function void push_word(logic action, int voice, logic [FREQ_W-1:0] f1,
			logic [FREQ_W-1:0] f2, logic [FREQ_W-1:0] f3, logic last);
			voice_word_t w;
			w.action      = action;
			w.voice       = VOICE_W'(voice);
			w.freq_main   = f1;
			w.freq_second = f2;
			w.freq_third  = f3;
			w.last        = last;
			pending.push_back(w);
		endfunction

		function void note_item(logic [FUNC_W-1:0] func, logic [NOTE_W-1:0] note,
			logic [FREQ_W-1:0] freq);
			int                v;
			longint            f;
			logic [FREQ_W-1:0] fm;
			case (func)
				FUNC_START: begin
					if (note == 0)
						return;
					foreach (held[i])
						if (held[i] == note)
							return;
					if (free_count > 0) begin
						v          = free_voices[head];
						head       = (head + 1) % VOICES;
						free_count = free_count - 1;
					end else begin
						v = 0;  // steal voice 0
					end
					f = longint'(freq) + longint'(shift_hz) * 16;
					if (f < 0)
						f = 0;
					if (f > longint'(FREQ_MAX))
						f = longint'(FREQ_MAX);
					fm = f[FREQ_W-1:0];
					held[v] = note;
					push_word(ACT_TRIGGER, v, fm, detune(fm, ratio_second),
						detune(fm, ratio_third), 1'b1);
				end
				FUNC_STOP: begin
					if (note == 0)
						return;
					for (int i = 0; i < VOICES; i++) begin
						if (held[i] == note) begin
							held[i] = '0;
							if (free_count < VOICES) begin
								free_voices[(head + free_count) % VOICES] = VOICE_W'(i);
								free_count = free_count + 1;
							end
							push_word(ACT_RELEASE, i, '0, '0, '0, 1'b1);
							return;
						end
					end
				end
				FUNC_STOP_ALL: begin
					for (int i = 0; i < VOICES; i++) begin
						held[i] = '0;
						push_word(ACT_RELEASE, i, '0, '0, '0, i == VOICES - 1);
					end
					refill();
				end
				default: ;
			endcase
		endfunction

		function void check_word(voice_word_t got);
			voice_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected voice word: act %0d voice %0d f %0d %0d %0d last %0d",
						got.action, got.voice, got.freq_main, got.freq_second,
						got.freq_third, got.last);
				return;
			end
			want = pending.pop_front();
			if (got.action !== want.action || got.voice !== want.voice ||
				got.freq_main !== want.freq_main || got.freq_second !== want.freq_second ||
				got.freq_third !== want.freq_third || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("voice word mismatch (act voice main second third last)");
					$display("  expected %0d %0d %0d %0d %0d %0d", want.action, want.voice,
						want.freq_main, want.freq_second, want.freq_third, want.last);
					$display("  actual   %0d %0d %0d %0d %0d %0d", got.action, got.voice,
						got.freq_main, got.freq_second, got.freq_third, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   quiet_cycles;

	pva_in_if  note_ch ();
	pva_out_if voice_ch ();
	pva_cfg_if cfg_ch ();

	voice_scoreboard sb = new();

	poly_voice_allocator #(
		.VOICES(VOICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.note_in(note_ch.sink),
		.voice_out(voice_ch.source),
		.cfg(cfg_ch.sink)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Observe all three channels at the edge where a word moves.
	always @(posedge clk) begin
		voice_word_t got;
		bit          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (note_ch.valid && note_ch.ready) begin
				sb.note_item(note_ch.func, note_ch.note_id, note_ch.frequency);
				moved = 1'b1;
			end
			if (voice_ch.valid && voice_ch.ready) begin
				got.action      = voice_ch.action;
				got.voice       = voice_ch.voice;
				got.freq_main   = voice_ch.freq_main;
				got.freq_second = voice_ch.freq_second;
				got.freq_third  = voice_ch.freq_third;
				got.last        = voice_ch.last;
				sb.check_word(got);
				moved = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				sb.write_reg(cfg_ch.addr, cfg_ch.data);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	// Stall the voice output in random bursts.
	initial begin
		voice_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		voice_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				voice_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				voice_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_note(input logic [FUNC_W-1:0] func, input logic [NOTE_W-1:0] note,
		input logic [FREQ_W-1:0] freq);
		note_ch.valid     <= 1'b1;
		note_ch.func      <= func;
		note_ch.note_id   <= note;
		note_ch.frequency <= freq;
		do @(posedge clk); while (!note_ch.ready);
		if (!calm && $urandom_range(0, 3) == 0) begin
			note_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected word is out and the block is idle.
	task automatic drain();
		note_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(input logic [SHIFT_W-1:0] shift, input logic [RATIO_W-1:0] r2,
		input logic [RATIO_W-1:0] r3);
		drain();
		write_reg(REG_SHIFT_HZ, CFG_DATA_W'(shift));
		write_reg(REG_RATIO_SECOND, r2);
		write_reg(REG_RATIO_THIRD, r3);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FREQ_MAX;
			2: return FREQ_W'($urandom_range(0, 40000));
			default: return FREQ_W'($urandom);
		endcase
	endfunction

	function automatic logic [RATIO_W-1:0] pick_ratio();
		if ($urandom_range(0, 1) == 0)
			return RATIO_W'($urandom_range(49152, 98304));
		return RATIO_W'($urandom);
	endfunction

	// Mostly starts and stops of held notes; some stop-alls and noise.
	task automatic random_item();
		int                pick;
		logic [NOTE_W-1:0] note;
		int                busy [$];
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			note = ($urandom_range(0, 2) == 0) ? NOTE_W'($urandom_range(1, 12))
				: NOTE_W'($urandom_range(1, 255));
			send_note(FUNC_START, note, pick_freq());
		end else if (pick < 80) begin
			foreach (sb.held[i])
				if (sb.held[i] != 0)
					busy.push_back(i);
			if (busy.size() > 0)
				note = sb.held[busy[$urandom_range(0, busy.size() - 1)]];
			else
				note = NOTE_W'($urandom_range(1, 255));
			send_note(FUNC_STOP, note, pick_freq());
		end else if (pick < 86) begin
			send_note(FUNC_STOP, NOTE_W'($urandom_range(0, 255)), pick_freq());
		end else if (pick < 91) begin
			send_note(FUNC_STOP_ALL, NOTE_W'($urandom), pick_freq());
		end else if (pick < 95) begin
			send_note(FUNC_UNUSED, NOTE_W'($urandom), pick_freq());
		end else begin
			send_note(($urandom_range(0, 1) == 0) ? FUNC_START : FUNC_STOP, '0, pick_freq());
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		calm              = 1'b0;
		note_ch.valid     <= 1'b0;
		note_ch.func      <= FUNC_START;
		note_ch.note_id   <= '0;
		note_ch.frequency <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.addr       <= REG_SHIFT_HZ;
		cfg_ch.data       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, held note, note zero, unheld stop, unused code,
		// voice stealing once the free list is empty, then stop-all.
		send_note(FUNC_START, 8'd1, '0);
		send_note(FUNC_START, 8'd255, FREQ_MAX);
		send_note(FUNC_START, 8'd1, 19'd1234);
		send_note(FUNC_START, 8'd0, 19'd500);
		send_note(FUNC_STOP, 8'd0, '0);
		send_note(FUNC_STOP, 8'd77, '0);
		send_note(FUNC_UNUSED, 8'd5, 19'h2AAAA);
		send_note(FUNC_STOP, 8'd255, '0);
		for (int n = 10; n < 17; n++)
			send_note(FUNC_START, NOTE_W'(n), FREQ_W'(n * 4099));
		send_note(FUNC_START, 8'd20, 19'h55555);
		send_note(FUNC_STOP, 8'd1, '0);
		send_note(FUNC_STOP, 8'd20, '0);
		send_note(FUNC_STOP_ALL, '0, '0);
		send_note(FUNC_START, 8'd128, 19'h7FFF0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(12'sd2047, {RATIO_W{1'b1}}, '0);
				1: configure(-12'sd2048, '0, {RATIO_W{1'b1}});
				default: configure(SHIFT_W'($urandom), pick_ratio(), pick_ratio());
			endcase
			calm = (phase == 5);
			for (int k = 0; k < RANDOM_PHASE; k++)
				random_item();
		end

		drain();
		if (sb.pending.size() != 0)
			$display("expected voice words never arrived: %0d", sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
